### hdl/bfvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfvs_pkg
// Shared types, widths and constants of the byte ring FIFO with varint
// coding and pattern search.
// ----------------------------------------------------------------------------
package bfvs_pkg;

   // Default storage depth and longest search pattern.
   localparam int DEPTH_DEFAULT       = 1024;
   localparam int MAX_PATTERN_DEFAULT = 8;

   // Field widths of the request, result and ring size register.
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int OFFSET_W = 16;
   localparam int PAT_W    = 64;
   localparam int PLEN_W   = 4;
   localparam int RES_W    = 10;
   localparam int RING_W   = 11;

   // Ring size after reset.
   localparam int RING_RESET = 1024;

   // Varint length thresholds.
   localparam logic [VALUE_W-1:0] VAR_LIM1 = 32'd128;
   localparam logic [VALUE_W-1:0] VAR_LIM2 = 32'd16384;
   localparam logic [VALUE_W-1:0] VAR_LIM3 = 32'd2097152;
   localparam logic [VALUE_W-1:0] VAR_LIM4 = 32'd268435456;
   localparam logic [7:0]         VAR_MASK = 8'h7f;
   localparam logic [7:0]         VAR_CONT = 8'h80;

   // Request codes.
   typedef enum logic [OP_W-1:0] {
      OP_WR_BYTE = 3'd0,
      OP_RD_BYTE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_WR_VAR  = 3'd3,
      OP_RD_VAR  = 3'd4,
      OP_SEEK    = 3'd5,
      OP_FIND    = 3'd6,
      OP_CLEAR   = 3'd7
   } op_type;

   // Sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_VWR  = 6'b000100,
      ST_RD   = 6'b001000,
      ST_CK   = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

endpackage

### hdl/byte_ring_fifo_varint_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_varint_search
// Byte ring FIFO with varint write and read, seek, pattern find and clear.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Word
//  req_     in         req_valid/stall    request type and operands
//  rsp_     out        rsp_valid/stall    ok, value, count, position, fill
//  csr_     in         csr_wr_en          ring size, also empties the FIFO
//
// A word is latched in IDLE, executed in EXEC and posted from DONE to the
// output register. Varint writes visit VWR once per byte written; reads,
// peeks, varint reads and finds visit RD and CK per byte read from the store
// (registered read port); a find reads up to fill times pattern length bytes.
// Reset is synchronous and clears the pointers; the store is not cleared.
// A stalled result holds in the output register and blocks the next result.
// ----------------------------------------------------------------------------
module byte_ring_fifo_varint_search #(
   parameter int DEPTH       = bfvs_pkg::DEPTH_DEFAULT,
   parameter int MAX_PATTERN = bfvs_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bfvs_pkg::OP_W-1:0]     req_type,
   input  logic [bfvs_pkg::VALUE_W-1:0]  req_value,
   input  logic [bfvs_pkg::OFFSET_W-1:0] req_offset,
   input  logic [bfvs_pkg::PAT_W-1:0]    req_pattern,
   input  logic [bfvs_pkg::PLEN_W-1:0]   req_pattern_len,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic [bfvs_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [bfvs_pkg::RES_W-1:0]    rsp_count,
   output logic [bfvs_pkg::RES_W-1:0]    rsp_position,
   output logic [bfvs_pkg::RES_W-1:0]    rsp_fill_level,
   input  logic                         csr_wr_en,
   input  logic [bfvs_pkg::RING_W-1:0]   csr_wr_data
);
   import bfvs_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int SZ_W = AW + 1;
   localparam int CW   = (SZ_W > RING_W) ? SZ_W : RING_W;
   localparam int RESET_SIZE = (RING_RESET > DEPTH) ? DEPTH : RING_RESET;

   state_type state_ff, state_in;

   logic [SZ_W-1:0] size_ff, size_in;
   logic [SZ_W-1:0] head_ff, head_in;
   logic [SZ_W-1:0] tail_ff, tail_in;

   // Latched request.
   op_type              op_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [OFFSET_W-1:0] off_ff;
   logic [PAT_W-1:0]    pat_ff;
   logic [PLEN_W-1:0]   plen_ff;

   // Working registers.
   logic [SZ_W-1:0]    p_ff, p_in;
   logic [SZ_W-1:0]    start_ff, start_in;
   logic [SZ_W-1:0]    i_ff, i_in;
   logic [2:0]         j_ff, j_in;
   logic [VALUE_W-1:0] d_ff, d_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;

   // Result being built.
   logic               ok_ff, ok_in;
   logic [VALUE_W-1:0] rv_ff, rv_in;
   logic [SZ_W-1:0]    cnt_ff, cnt_in;
   logic [SZ_W-1:0]    pos_ff, pos_in;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [VALUE_W-1:0] rsp_rv_ff;
   logic [RES_W-1:0]   rsp_cnt_ff;
   logic [RES_W-1:0]   rsp_pos_ff;
   logic [RES_W-1:0]   rsp_fill_ff;

   // Store ports.
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   logic [SZ_W-1:0] fill;
   logic [CW-1:0]   rs_wide;
   logic [2:0]      var_len;
   logic            out_free;
   logic            req_accept;

   // Pointer step with wrap at the ring end.
   function automatic logic [SZ_W-1:0] inc_ptr(input logic [SZ_W-1:0] p,
                                                 input logic [SZ_W-1:0] s);
      logic [SZ_W:0] n;
      n = {1'b0, p} + 1'b1;
      return (n >= {1'b0, s}) ? '0 : n[SZ_W-1:0];
   endfunction

   bfvs_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Fill level from the pointers.
   assign fill = (head_ff >= tail_ff) ? (head_ff - tail_ff)
                                      : (head_ff + size_ff - tail_ff);

   // Clamped ring size for a register write.
   always_comb begin
      rs_wide = CW'(csr_wr_data);
      if (rs_wide < CW'(2)) begin
         size_in = SZ_W'(2);
      end else if (rs_wide > CW'(DEPTH)) begin
         size_in = SZ_W'(DEPTH);
      end else begin
         size_in = SZ_W'(rs_wide);
      end
   end

   // Varint length of the latched value.
   always_comb begin
      if (val_ff < VAR_LIM1) begin
         var_len = 3'd1;
      end else if (val_ff < VAR_LIM2) begin
         var_len = 3'd2;
      end else if (val_ff < VAR_LIM3) begin
         var_len = 3'd3;
      end else if (val_ff < VAR_LIM4) begin
         var_len = 3'd4;
      end else begin
         var_len = 3'd5;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mem_raddr  = p_ff[AW-1:0];

   // Sequencer.
   always_comb begin
      logic [SZ_W-1:0] pn;
      logic [SZ_W:0]   t;
      logic [SZ_W-1:0] k;
      logic [5:0]      shamt;
      logic [SZ_W-1:0] i_next;

      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      p_in      = p_ff;
      start_in  = start_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;
      ok_in     = ok_ff;
      rv_in     = rv_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      mem_we    = 1'b0;
      mem_waddr = p_ff[AW-1:0];
      mem_wdata = '0;

      pn     = inc_ptr(p_ff, size_ff);
      t      = '0;
      k      = '0;
      shamt  = 6'(i_ff[2:0]) * 6'd7;
      i_next = i_ff + 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            ok_in    = 1'b0;
            rv_in    = '0;
            cnt_in   = '0;
            pos_in   = '0;
            state_in = ST_DONE;
            case (op_ff)
               OP_WR_BYTE: begin
                  if (fill + 1'b1 < size_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = head_ff[AW-1:0];
                     mem_wdata = val_ff[7:0];
                     head_in   = inc_ptr(head_ff, size_ff);
                     ok_in     = 1'b1;
                     cnt_in    = SZ_W'(1);
                  end
               end
               OP_RD_BYTE, OP_PEEK, OP_RD_VAR: begin
                  if (fill != '0) begin
                     p_in     = tail_ff;
                     i_in     = '0;
                     acc_in   = '0;
                     state_in = ST_RD;
                  end
               end
               OP_WR_VAR: begin
                  if (size_ff - 1'b1 - fill >= SZ_W'(var_len)) begin
                     d_in     = val_ff;
                     p_in     = head_ff;
                     cnt_in   = SZ_W'(var_len);
                     state_in = ST_VWR;
                  end
               end
               OP_SEEK: begin
                  k = (32'(off_ff) < 32'(fill)) ? SZ_W'(off_ff) : fill;
                  t = {1'b0, tail_ff} + {1'b0, k};
                  if (t >= {1'b0, size_ff}) begin
                     t = t - {1'b0, size_ff};
                  end
                  tail_in = t[SZ_W-1:0];
                  ok_in   = 1'b1;
                  cnt_in  = k;
               end
               OP_FIND: begin
                  if (plen_ff != '0 && 32'(plen_ff) <= MAX_PATTERN
                      && 32'(plen_ff) <= 32'(fill)) begin
                     p_in     = tail_ff;
                     start_in = tail_ff;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_RD;
                  end
               end
               OP_CLEAR: begin
                  head_in = '0;
                  tail_in = '0;
                  ok_in   = 1'b1;
               end
               default: begin
               end
            endcase
         end

         // One varint byte a cycle, low group first.
         ST_VWR: begin
            mem_we    = 1'b1;
            mem_wdata = (d_ff[7 +: 25] != '0) ? (d_ff[7:0] & VAR_MASK) | VAR_CONT
                                              : (d_ff[7:0] & VAR_MASK);
            d_in      = d_ff >> 7;
            p_in      = pn;
            if (d_ff[7 +: 25] == '0) begin
               head_in  = pn;
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end

         // Read address is on the port; data arrives next cycle.
         ST_RD: begin
            state_in = ST_CK;
         end

         ST_CK: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_RD_BYTE, OP_PEEK: begin
                  rv_in = VALUE_W'(mem_rdata);
                  ok_in = 1'b1;
                  if (op_ff == OP_RD_BYTE) begin
                     tail_in = pn;
                     cnt_in  = SZ_W'(1);
                  end
               end
               OP_RD_VAR: begin
                  acc_in = acc_ff | (VALUE_W'(mem_rdata & VAR_MASK) << shamt);
                  if (!mem_rdata[7]) begin
                     ok_in   = 1'b1;
                     cnt_in  = i_next;
                     rv_in   = acc_in;
                     tail_in = pn;
                  end else if (i_next != SZ_W'(5) && i_next != fill) begin
                     i_in     = i_next;
                     p_in     = pn;
                     state_in = ST_RD;
                  end
               end
               OP_FIND: begin
                  if (mem_rdata == pat_ff[8*j_ff +: 8]) begin
                     if (4'(j_ff) + 4'd1 == plen_ff) begin
                        ok_in  = 1'b1;
                        pos_in = i_ff;
                     end else begin
                        j_in     = j_ff + 1'b1;
                        p_in     = pn;
                        state_in = ST_RD;
                     end
                  end else if (32'(i_next) + 32'(plen_ff) <= 32'(fill)) begin
                     i_in     = i_next;
                     start_in = inc_ptr(start_ff, size_ff);
                     p_in     = start_in;
                     j_in     = '0;
                     state_in = ST_RD;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SZ_W'(RESET_SIZE);
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            size_ff <= size_in;
            head_ff <= '0;
            tail_ff <= '0;
         end else begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      logic [31:0] w_cnt, w_pos, w_fill;
      w_cnt  = 32'(cnt_ff);
      w_pos  = 32'(pos_ff);
      w_fill = 32'(fill);
      if (req_accept) begin
         op_ff   <= op_type'(req_type);
         val_ff  <= req_value;
         off_ff  <= req_offset;
         pat_ff  <= req_pattern;
         plen_ff <= req_pattern_len;
      end
      p_ff     <= p_in;
      start_ff <= start_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      d_ff     <= d_in;
      acc_ff   <= acc_in;
      ok_ff    <= ok_in;
      rv_ff    <= rv_in;
      cnt_ff   <= cnt_in;
      pos_ff   <= pos_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_ok_ff   <= ok_ff;
         rsp_rv_ff   <= rv_ff;
         rsp_cnt_ff  <= w_cnt[RES_W-1:0];
         rsp_pos_ff  <= w_pos[RES_W-1:0];
         rsp_fill_ff <= w_fill[RES_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_rv_ff;
   assign rsp_count      = rsp_cnt_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_fill_level = rsp_fill_ff;

endmodule

### hdl/bfvs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfvs_ram
// Byte store with one write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bfvs_ram #(
   parameter int DEPTH = bfvs_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   import bfvs_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/tb_byte_ring_fifo_varint_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_varint_search
// Self-checking bench for the byte ring FIFO. Request words are queued by an
// initial block, driven with random gaps, and every response word is checked
// against an in-bench model of the ring, varint coding, seek and find.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_varint_search;
   import bfvs_pkg::*;

   typedef struct {
      op_type      op;
      logic [31:0] value;
      logic [15:0] offset;
      logic [63:0] pattern;
      logic [3:0]  plen;
   } req_word_type;

   typedef struct {
      logic        ok;
      logic [31:0] read_value;
      logic [9:0]  count;
      logic [9:0]  position;
      logic [9:0]  fill_level;
   } rsp_word_type;

   localparam int LIMIT = 4000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_type = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic [OFFSET_W-1:0] req_offset = '0;
   logic [PAT_W-1:0]    req_pattern = '0;
   logic [PLEN_W-1:0]   req_pattern_len = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_ok;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic [RES_W-1:0]    rsp_count;
   logic [RES_W-1:0]    rsp_position;
   logic [RES_W-1:0]    rsp_fill_level;
   logic                csr_wr_en = 1'b0;
   logic [RING_W-1:0]   csr_wr_data = '0;

   req_word_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   int        errors = 0;
   int        cycles = 0;
   int        rsp_seen = 0;
   int        found_hits = 0;
   int        hold_off = 0;
   int        send_gap = 0;
   bit        long_hold_done = 0;

   // Model state of the ring.
   logic [7:0] ring_mem[1024];
   int         head_idx, tail_idx, ring_len;

   byte_ring_fifo_varint_search dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int ring_fill();
      return (head_idx >= tail_idx) ? head_idx - tail_idx : head_idx + ring_len - tail_idx;
   endfunction

   function automatic int ring_next(int p);
      return (p + 1 >= ring_len) ? 0 : p + 1;
   endfunction

   // Apply one request word to the model and return the response it should give.
   function automatic rsp_word_type ring_apply(req_word_type r);
      rsp_word_type o;
      int          fill, len, p, k, i, j, start;
      logic [31:0] d;
      logic [63:0] acc;
      logic [7:0]  b;
      o = '{0, 0, 0, 0, 0};
      fill = ring_fill();
      case (r.op)
         OP_WR_BYTE: begin
            if (fill + 1 < ring_len) begin
               ring_mem[head_idx] = r.value[7:0];
               head_idx = ring_next(head_idx);
               o.ok = 1; o.count = 1;
            end
         end
         OP_RD_BYTE, OP_PEEK: begin
            if (fill != 0) begin
               o.read_value = ring_mem[tail_idx];
               o.ok = 1;
               if (r.op == OP_RD_BYTE) begin
                  tail_idx = ring_next(tail_idx);
                  o.count = 1;
               end
            end
         end
         OP_WR_VAR: begin
            len = (r.value < 128) ? 1 : (r.value < 16384) ? 2 :
                  (r.value < 2097152) ? 3 : (r.value < 268435456) ? 4 : 5;
            if (ring_len - 1 - fill >= len) begin
               d = r.value;
               for (i = 0; i < len; i++) begin
                  b = {1'b0, d[6:0]};
                  d = d >> 7;
                  if (d != 0) b[7] = 1'b1;
                  ring_mem[head_idx] = b;
                  head_idx = ring_next(head_idx);
               end
               o.ok = 1; o.count = len;
            end
         end
         OP_RD_VAR: begin
            acc = '0;
            p = tail_idx;
            for (i = 0; i < ((fill > 5) ? 5 : fill); i++) begin
               b = ring_mem[p];
               acc |= 64'(b[6:0]) << (7 * i);
               p = ring_next(p);
               if (!b[7]) begin
                  o.ok = 1; o.count = i + 1;
                  o.read_value = acc[31:0];
                  tail_idx = p;
                  break;
               end
            end
         end
         OP_SEEK: begin
            k = (r.offset < fill) ? r.offset : fill;
            tail_idx = tail_idx + k;
            if (tail_idx >= ring_len) tail_idx -= ring_len;
            o.ok = 1; o.count = k;
         end
         OP_FIND: begin
            if (r.plen >= 1 && r.plen <= 8 && r.plen <= fill) begin
               start = tail_idx;
               for (i = 0; i + r.plen <= fill; i++) begin
                  p = start;
                  for (j = 0; j < r.plen; j++) begin
                     if (ring_mem[p] != r.pattern[8*j +: 8]) break;
                     p = ring_next(p);
                  end
                  if (j == r.plen) begin
                     o.ok = 1; o.position = i;
                     break;
                  end
                  start = ring_next(start);
               end
            end
         end
         default: begin
            head_idx = 0; tail_idx = 0;
            o.ok = 1;
         end
      endcase
      o.fill_level = ring_fill();
      return o;
   endfunction

   function automatic req_word_type make_req(op_type op, logic [31:0] v, logic [15:0] off,
                                             logic [63:0] pat, logic [3:0] plen);
      req_word_type r;
      r.op = op; r.value = v; r.offset = off; r.pattern = pat; r.plen = plen;
      return r;
   endfunction

   // Random word weighted toward traffic that keeps the ring busy.
   function automatic req_word_type random_req();
      req_word_type r;
      int        pick;
      r = make_req(op_type'($urandom_range(0, 7)), $urandom, $urandom, {$urandom, $urandom},
                   $urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 25) r.op = OP_WR_BYTE;
      else if (pick < 40) r.op = OP_WR_VAR;
      else if (pick < 55) r.op = OP_RD_VAR;
      else if (pick < 68) r.op = OP_RD_BYTE;
      else if (pick < 74) r.op = OP_PEEK;
      else if (pick < 90) r.op = OP_FIND;
      else if (pick < 97) r.op = OP_SEEK;
      else r.op = OP_CLEAR;
      if ($urandom_range(0, 3) != 0) r.value = r.value >> $urandom_range(0, 31);
      if ($urandom_range(0, 3) != 0) r.offset = $urandom_range(0, 6);
      if (r.op == OP_FIND && $urandom_range(0, 3) != 0) begin
         // Small alphabet so that patterns actually match.
         r.pattern = {$urandom, $urandom} & 64'h0303030303030303;
         r.plen = $urandom_range(1, 3);
      end
      if (r.op == OP_WR_BYTE && $urandom_range(0, 1)) r.value[7:0] = $urandom_range(0, 3);
      return r;
   endfunction

   // Driver: offers queued words, predicting each response as it is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(ring_apply(pending_reqs.pop_front()));
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_type <= pending_reqs[0].op;
               req_value <= pending_reqs[0].value;
               req_offset <= pending_reqs[0].offset;
               req_pattern <= pending_reqs[0].pattern;
               req_pattern_len <= pending_reqs[0].plen;
               send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 1) * $urandom_range(0, 2);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted response word and paces the stall.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0) begin
               $error("response word with nothing expected");
               errors++;
            end else begin
               rsp_word_type e;
               e = expected_rsps.pop_front();
               if (e.ok) found_hits <= found_hits + 1;
               if (rsp_ok !== e.ok) begin
                  $error("ok: expected %0d, got %0d", e.ok, rsp_ok); errors++;
               end
               if (rsp_read_value !== e.read_value) begin
                  $error("read_value: expected %0h, got %0h", e.read_value, rsp_read_value);
                  errors++;
               end
               if (rsp_count !== e.count) begin
                  $error("count: expected %0d, got %0d", e.count, rsp_count); errors++;
               end
               if (rsp_position !== e.position) begin
                  $error("position: expected %0d, got %0d", e.position, rsp_position); errors++;
               end
               if (rsp_fill_level !== e.fill_level) begin
                  $error("fill_level: expected %0d, got %0d", e.fill_level, rsp_fill_level);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_seen >= 300 && !long_hold_done) begin
            // One long hold so the request side backs up.
            long_hold_done <= 1'b1;
            hold_off <= 400;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            hold_off <= $urandom_range(1, 30);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0) && (rsp_seen % 200 > 50);
         end
      end
      if (cycles >= LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Wait until every queued word is sent and answered, then settle.
   task automatic drain_all();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Set the ring size while idle; the model empties with it.
   task automatic set_ring(int sz);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= sz[RING_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ring_len = (sz < 2) ? 2 : (sz > 1024) ? 1024 : sz;
      head_idx = 0; tail_idx = 0;
   endtask

   initial begin
      int sizes[6];
      int n, i;
      head_idx = 0; tail_idx = 0; ring_len = 1024;
      foreach (ring_mem[m]) ring_mem[m] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, varint extremes, find cases, seek and clear.
      pending_reqs.push_back(make_req(OP_RD_BYTE, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_PEEK, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_RD_VAR, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(OP_WR_BYTE, 32'hFFFF_FFFF, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_WR_BYTE, 32'h0000_0100, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_RD_VAR, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_WR_VAR, 32'd127, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_WR_VAR, 32'd128, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_WR_VAR, 32'd16384, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_WR_VAR, 32'd2097152, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_WR_VAR, 32'hFFFF_FFFF, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_FIND, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
      pending_reqs.push_back(make_req(OP_FIND, 0, 0, 64'h0000_0000_0000_8001, 2));
      pending_reqs.push_back(make_req(OP_FIND, 0, 0, 64'h0F_FF_FF_FF_FF_FF_00_FF, 8));
      pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 4'hF));
      pending_reqs.push_back(make_req(OP_PEEK, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_RD_BYTE, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_RD_VAR, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_RD_VAR, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_SEEK, 0, 16'd3, 0, 0));
      pending_reqs.push_back(make_req(OP_SEEK, 0, 16'hFFFF, 0, 0));
      pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0));
      drain_all();

      // Random phases over several ring sizes, the extremes among them.
      sizes = '{2, 5, 16, 1024, 0, 2047};
      for (n = 0; n < 6; n++) begin
         set_ring(sizes[n]);
         for (i = 0; i < 150; i++) pending_reqs.push_back(random_req());
         drain_all();
      end

      $display("Covered 23 directed and 900 random request words over six ring sizes,");
      $display("%0d response words checked, %0d reported success.", rsp_seen, found_hits);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
